// File: rtl/icc_pkg.sv
// Package for the integer column codec selector.
// Holds the counter width, codec codes, statistics record and bit helpers.
// No dependencies.
`default_nettype none

package icc_pkg;

    localparam int COUNT_WIDTH = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [COUNT_WIDTH+1:0] t_wide;
    typedef logic [63:0]            t_word;
    typedef logic [6:0]             t_bits;

    localparam t_count COUNT_MAX = '1;
    localparam t_word  TOP_BIT   = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        CODEC_PLAIN    = 3'd0,
        CODEC_DELTADD  = 3'd1,
        CODEC_RLE      = 3'd2,
        CODEC_FOR      = 3'd3,
        CODEC_DELTAFOR = 3'd4,
        CODEC_DELTA    = 3'd5,
        CODEC_SIMPLE8B = 3'd6,
        CODEC_DIRECT   = 3'd7
    } t_codec;

    // Running statistics of the column in progress
    typedef struct packed {
        t_count count;
        t_word  pdelta;
        t_count nz;
        t_word  dmin;
        t_word  dmax;
        t_word  smin;
        t_word  smax;
        t_word  umin;
        t_word  umax;
        t_count cur;
        t_count runs;
        t_count rep;
        logic   nondec;
        logic   allfit;
        t_bits  wad;
        t_bits  wav;
        t_bits  wub;
    } t_stats;

    localparam t_stats STATS_RESET = '{
        count: '0, pdelta: '0, nz: '0, dmin: '0, dmax: '0, smin: '0, smax: '0,
        umin: '0, umax: '0, cur: '0, runs: '0, rep: '0, nondec: 1'b1,
        allfit: 1'b1, wad: '0, wav: '0, wub: '0
    };

    // Number of significant bits; zero counts as one bit
    function automatic t_bits bit_width(input t_word v);
        t_bits w;
        w = 7'd1;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) w = t_bits'(i + 1);
        end
        return w;
    endfunction

    // Two's complement magnitude, wrapping for the most negative value
    function automatic t_word abs_val(input t_word v);
        return v[63] ? (t_word'(0) - v) : v;
    endfunction

    function automatic logic slt(input t_word a, input t_word b);
        return (a ^ TOP_BIT) < (b ^ TOP_BIT);
    endfunction

    function automatic t_count sat_inc(input t_count x);
        return (x == COUNT_MAX) ? COUNT_MAX : x + t_count'(1);
    endfunction

    function automatic t_count sat_add(input t_count a, input t_count b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic t_bits max_bits(input t_bits a, input t_bits b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/integer_column_codec_selector.sv
// Integer column codec selector: five register stages from input to codec.
// A column's last element passes the snapshot, range, flag and output registers.
// Throughput: one element per cycle; the input register, statistics update and three
// decision stages each move on as soon as the next one is free.
// Reset (synchronous, active low) clears all statistics and empties every stage.
// Depends on icc_pkg.
`default_nettype none

module integer_column_codec_selector
    import icc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_value,
    input  wire logic        i_is_unsigned,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_codec
);

    // Stage 0: input register with precomputed delta and neighbor compares
    logic   r_in_valid;
    t_word  r_in_value;
    logic   r_in_uns;
    logic   r_in_last;
    t_word  r_in_delta;
    logic   r_in_eq;
    logic   r_in_lt;

    // Stage 1: live statistics and snapshot of a finished column
    t_stats r_stats, n_stats;
    logic   r_snap_valid;
    t_stats r_snap;
    logic   r_snap_uns;

    // Stage 2: ranges and run totals
    logic   r_rng_valid;
    logic   r_rng_uns, r_rng_allfit, r_rng_nondec;
    t_bits  r_rng_wad, r_rng_wav, r_rng_wub;
    t_count r_rng_n, r_rng_nz, r_rng_runs, r_rng_rep;
    t_word  r_rng_urange, r_rng_drange, r_rng_srange;

    // Stage 3: decision flags
    logic   r_flg_valid;
    logic   r_flg_uns, r_flg_allfit, r_flg_nondec;
    t_bits  r_flg_wad, r_flg_wav, r_flg_wub;
    logic   r_flg_lt4, r_flg_ge8, r_flg_rle, r_flg_dd;
    t_bits  r_flg_urb, r_flg_drb, r_flg_rb;

    // Stage 4: output register
    logic   r_out_valid;
    t_codec r_codec, n_codec;

    // Ready chain, back to front
    logic rdy4, rdy3, rdy2, rdy1, adv0, in_xfer;

    assign rdy4    = !r_out_valid || !i_stall;
    assign rdy3    = !r_flg_valid || rdy4;
    assign rdy2    = !r_rng_valid || rdy3;
    assign rdy1    = !r_snap_valid || rdy2;
    assign adv0    = r_in_valid && (!r_in_last || rdy1);
    assign o_stall = r_in_valid && !adv0;
    assign in_xfer = i_valid && !o_stall;

    // Input register; r_in_value still holds the previous element at transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (adv0) begin
            r_in_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_in_value <= i_value;
            r_in_uns   <= i_is_unsigned;
            r_in_last  <= i_last;
            r_in_delta <= i_value - r_in_value;
            r_in_eq    <= (i_value == r_in_value);
            r_in_lt    <= slt(i_value, r_in_value);
        end
    end

    // Statistics update for the element in the input register
    logic  first;
    t_bits bw_abs_v, bw_abs_d;

    assign first    = (r_stats.count == '0);
    assign bw_abs_v = bit_width(abs_val(r_in_value));
    assign bw_abs_d = bit_width(abs_val(r_in_delta));

    always_comb begin
        n_stats = r_stats;
        if (first) begin
            n_stats.pdelta = r_in_value;
            n_stats.dmin   = r_in_value;
            n_stats.dmax   = r_in_value;
            n_stats.smin   = r_in_value;
            n_stats.smax   = r_in_value;
            n_stats.umin   = r_in_value;
            n_stats.umax   = r_in_value;
            n_stats.cur    = t_count'(1);
            n_stats.wad    = bw_abs_v;
        end else begin
            if (r_in_delta != r_stats.pdelta) n_stats.nz = sat_inc(r_stats.nz);
            n_stats.pdelta = r_in_delta;
            if (slt(r_in_delta, r_stats.dmin)) n_stats.dmin = r_in_delta;
            if (slt(r_stats.dmax, r_in_delta)) n_stats.dmax = r_in_delta;
            n_stats.wad = max_bits(r_stats.wad, bw_abs_d);
            if (r_in_eq) begin
                n_stats.cur = sat_inc(r_stats.cur);
            end else begin
                n_stats.runs = sat_inc(r_stats.runs);
                if (r_stats.cur > t_count'(1)) n_stats.rep = sat_add(r_stats.rep, r_stats.cur);
                n_stats.cur = t_count'(1);
            end
            if (r_in_lt) n_stats.nondec = 1'b0;
            if (slt(r_in_value, r_stats.smin)) n_stats.smin = r_in_value;
            if (slt(r_stats.smax, r_in_value)) n_stats.smax = r_in_value;
            if (r_in_value < r_stats.umin) n_stats.umin = r_in_value;
            if (r_in_value > r_stats.umax) n_stats.umax = r_in_value;
        end
        if (r_in_value[63]) n_stats.allfit = 1'b0;
        n_stats.wav   = max_bits(r_stats.wav, bw_abs_v);
        n_stats.wub   = max_bits(r_stats.wub, bit_width(r_in_value));
        n_stats.count = sat_inc(r_stats.count);
    end

    // Live statistics return to reset once a column's last element is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stats      <= STATS_RESET;
            r_snap_valid <= 1'b0;
        end else begin
            if (adv0) r_stats <= r_in_last ? STATS_RESET : n_stats;
            if (rdy1) r_snap_valid <= r_in_valid && r_in_last;
        end
        if (rdy1 && r_in_valid && r_in_last) begin
            r_snap     <= n_stats;
            r_snap_uns <= r_in_uns;
        end
    end

    // Stage 2: ranges and closing of the open run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng_valid <= 1'b0;
        end else if (rdy2) begin
            r_rng_valid <= r_snap_valid;
        end
        if (rdy2 && r_snap_valid) begin
            r_rng_uns    <= r_snap_uns;
            r_rng_allfit <= r_snap.allfit;
            r_rng_nondec <= r_snap.nondec;
            r_rng_wad    <= r_snap.wad;
            r_rng_wav    <= r_snap.wav;
            r_rng_wub    <= r_snap.wub;
            r_rng_n      <= r_snap.count;
            r_rng_nz     <= r_snap.nz;
            r_rng_runs   <= sat_inc(r_snap.runs);
            r_rng_rep    <= (r_snap.cur > t_count'(1)) ? sat_add(r_snap.rep, r_snap.cur)
                                                       : r_snap.rep;
            r_rng_urange <= r_snap.umax - r_snap.umin;
            r_rng_drange <= r_snap.dmax - r_snap.dmin;
            r_rng_srange <= r_snap.smax - r_snap.smin;
        end
    end

    // Stage 3: exact ratio tests and range widths
    t_wide n_wide, rep2, runs3, nz4, nm1;

    assign n_wide = {2'b00, r_rng_n};
    assign rep2   = {1'b0, r_rng_rep, 1'b0};
    assign runs3  = {2'b00, r_rng_runs} + {1'b0, r_rng_runs, 1'b0};
    assign nz4    = {r_rng_nz, 2'b00};
    assign nm1    = n_wide - t_wide'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flg_valid <= 1'b0;
        end else if (rdy3) begin
            r_flg_valid <= r_rng_valid;
        end
        if (rdy3 && r_rng_valid) begin
            r_flg_uns    <= r_rng_uns;
            r_flg_allfit <= r_rng_allfit;
            r_flg_nondec <= r_rng_nondec;
            r_flg_wad    <= r_rng_wad;
            r_flg_wav    <= r_rng_wav;
            r_flg_wub    <= r_rng_wub;
            r_flg_lt4    <= (r_rng_n < t_count'(4));
            r_flg_ge8    <= (r_rng_n >= t_count'(8));
            r_flg_rle    <= (rep2 >= n_wide) && (n_wide >= runs3);
            r_flg_dd     <= (nz4 <= nm1);
            r_flg_urb    <= bit_width(r_rng_urange);
            r_flg_drb    <= bit_width(r_rng_drange);
            r_flg_rb     <= bit_width(r_rng_srange);
        end
    end

    // Codec priority
    logic [7:0] drb_plus3;

    assign drb_plus3 = {1'b0, r_flg_drb} + 8'd3;

    always_comb begin
        if (r_flg_uns && !r_flg_allfit) begin
            if (r_flg_lt4)                                n_codec = CODEC_DIRECT;
            else if (r_flg_rle)                           n_codec = CODEC_RLE;
            else if (r_flg_urb <= 7'd60)                  n_codec = CODEC_FOR;
            else if (r_flg_ge8 && r_flg_wub <= 7'd16)     n_codec = CODEC_SIMPLE8B;
            else if (r_flg_wub < 7'd64)                   n_codec = CODEC_DIRECT;
            else                                          n_codec = CODEC_PLAIN;
        end else begin
            if (r_flg_lt4)                                n_codec = CODEC_PLAIN;
            else if (r_flg_ge8 && (r_flg_dd || r_flg_drb <= 7'd2))
                                                          n_codec = CODEC_DELTADD;
            else if (r_flg_rle)                           n_codec = CODEC_RLE;
            else if (r_flg_rb <= 7'd60)                   n_codec = CODEC_FOR;
            else if (r_flg_ge8 && r_flg_nondec && drb_plus3 <= {1'b0, r_flg_rb})
                                                          n_codec = CODEC_DELTAFOR;
            else if (r_flg_wad <= 7'd61)                  n_codec = CODEC_DELTA;
            else if (r_flg_ge8 && r_flg_wav <= 7'd16 && !r_flg_nondec)
                                                          n_codec = CODEC_SIMPLE8B;
            else if (r_flg_wav < 7'd64)                   n_codec = CODEC_DIRECT;
            else                                          n_codec = CODEC_PLAIN;
        end
    end

    // Output register; holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy4) begin
            r_out_valid <= r_flg_valid;
        end
        if (rdy4 && r_flg_valid) begin
            r_codec <= n_codec;
        end
    end

    assign o_valid = r_out_valid;
    assign o_codec = r_codec;

endmodule

`default_nettype wire
